// ----- hdl/gme_pkg.sv -----
// Shared types and constants for the 3x3 gradient magnitude edge detector.
// No dependencies; every other file in the block imports this package.
package gme_pkg;

   // pixel and geometry widths
   localparam int PIX_W      = 8;
   localparam int MEM_DEPTH  = 1024;
   localparam int ADDR_W     = $clog2(MEM_DEPTH);
   localparam int COL_W      = 10;
   localparam int ROW_W      = 12;
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 13;
   localparam int MIN_SIZE   = 3;
   localparam int MAX_HEIGHT = 4096;
   localparam int WIN_SIZE   = 6;

   // arithmetic widths
   localparam int GRAD_W    = 11;   // signed gradient, |g| <= 1020
   localparam int ABS_W     = 10;   // unsigned kernel half-sums and |g|
   localparam int SQ_W      = 2 * ABS_W + 1;
   localparam int ROOT_W    = 8;
   localparam int ROOT_IN_W = 2 * ROOT_W;
   localparam logic [ROOT_W-1:0] MAG_SAT = '1;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_MODE  = 2'd2;

   localparam logic [WIDTH_W-1:0]  LINE_WIDTH_RST   = WIDTH_W'(1024);
   localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RST = HEIGHT_W'(4096);
   localparam logic                KERNEL_MODE_RST  = 1'b1;
   localparam logic                KERNEL_PREWITT   = 1'b0;

   typedef struct packed {
      logic [WIDTH_W-1:0]  line_width;
      logic [HEIGHT_W-1:0] frame_height;
      logic                kernel_mode;
   } gme_cfg_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // take pixel, read line stores
      logic advance;   // write line stores, shift window, step counters, gradients
      logic square;    // square and sum, start root
      logic out_load;  // load output register
   } gme_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic interior;
      logic root_busy;
      logic out_free;
   } gme_sts_type;

endpackage

// ----- hdl/gme_intf.sv -----
// Channel interfaces: pixel input, result output and configuration writes.
// Depends on gme_pkg for field widths.
interface gme_req_if import gme_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface gme_rsp_if import gme_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ROOT_W-1:0] magnitude;
   logic [ROW_W-1:0]  row;
   logic [COL_W-1:0]  column;
   logic              last_of_frame;
   modport source (output valid, output magnitude, output row, output column,
                   output last_of_frame, input ready);
   modport sink   (input valid, input magnitude, input row, input column,
                   input last_of_frame, output ready);
endinterface

interface gme_csr_if import gme_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/gme_isqrt.sv -----
// Iterative integer square root, one result bit per cycle (restoring method).
// Depends on gme_pkg for widths.
module gme_isqrt import gme_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [ROOT_IN_W-1:0] value,
   output logic                 busy,
   output logic [ROOT_W-1:0]    root
);
   localparam int REM_W = ROOT_W + 2;
   localparam int CNT_W = $clog2(ROOT_W);

   logic                 busy_ff, busy_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ROOT_IN_W-1:0] val_ff, val_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [REM_W+1:0]     shifted;
   logic [REM_W+1:0]     trial;
   logic [REM_W+1:0]     diff;

   // one digit step: bring down two bits, try subtracting 4*root+1
   always_comb begin
      shifted = {rem_ff, val_ff[ROOT_IN_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = shifted - trial;
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(ROOT_W - 1);
         val_in  = value;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         val_in = {val_ff[ROOT_IN_W-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in  = diff[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff  <= cnt_in;
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;
endmodule

// ----- hdl/gme_csr.sv -----
// Configuration registers: line width, frame height and kernel select.
// Depends on gme_pkg for register indexes and reset values.
module gme_csr import gme_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  csr_ready,
   output gme_cfg_type           cfg
);
   gme_cfg_type cfg_ff, cfg_in;

   // decode the register index; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_LINE_WIDTH:   cfg_in.line_width   = csr_data[WIDTH_W-1:0];
            REG_FRAME_HEIGHT: cfg_in.frame_height = csr_data[HEIGHT_W-1:0];
            REG_KERNEL_MODE:  cfg_in.kernel_mode  = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_width   <= LINE_WIDTH_RST;
         cfg_ff.frame_height <= FRAME_HEIGHT_RST;
         cfg_ff.kernel_mode  <= KERNEL_MODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;
endmodule

// ----- hdl/gme_ctrl.sv -----
// Sequencing state machine: one pixel word at a time through read, gradient,
// square, root and output. Depends on gme_pkg for command and status types.
module gme_ctrl import gme_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  gme_sts_type sts,
   output gme_cmd_type cmd
);
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_SQUARE = 3'd2;
   localparam logic [2:0] ST_ROOT   = 3'd3;
   localparam logic [2:0] ST_OUTPUT = 3'd4;

   logic [2:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.advance = 1'b1;
            state_in    = sts.interior ? ST_SQUARE : ST_IDLE;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_ROOT;
         end
         ST_ROOT: begin
            if (!sts.root_busy) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ----- hdl/gme_dpath.sv -----
// Datapath: line stores, 3x3 window, position counters, gradients, squaring,
// square root unit and output register. Depends on gme_pkg and gme_isqrt.
module gme_dpath import gme_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  gme_cmd_type       cmd,
   input  gme_cfg_type       cfg,
   output gme_sts_type       sts,
   input  logic [PIX_W-1:0]  pixel,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [ROOT_W-1:0] out_magnitude,
   output logic [ROW_W-1:0]  out_row,
   output logic [COL_W-1:0]  out_column,
   output logic              out_last
);
   // line stores, no reset: unwritten entries are read only for border pixels
   logic [PIX_W-1:0] upper_mem  [MEM_DEPTH];
   logic [PIX_W-1:0] middle_mem [MEM_DEPTH];

   logic [PIX_W-1:0] pix_ff, top_rd_ff, mid_rd_ff;
   logic [PIX_W-1:0] win_ff [WIN_SIZE];
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [WIDTH_W-1:0]  eff_w, col_nxt;
   logic [HEIGHT_W-1:0] eff_h, row_nxt;
   logic                interior, last_pos;

   logic [PIX_W:0]             kmr, kml, kbm, ktm;
   logic [ABS_W-1:0]           pos_x, neg_x, pos_y, neg_y;
   logic signed [GRAD_W-1:0]   gx_in, gy_in, gx_ff, gy_ff;
   logic [ABS_W-1:0]           ax, ay;
   logic [2*ABS_W-1:0]         sqx, sqy;
   logic [SQ_W-1:0]            sq_sum;
   logic                       sat_ff;
   logic [ROW_W-1:0]           res_row_ff;
   logic [COL_W-1:0]           res_col_ff;
   logic                       res_last_ff;

   logic                root_busy;
   logic [ROOT_W-1:0]   root;

   logic                out_valid_ff;
   logic [ROOT_W-1:0]   out_mag_ff;
   logic [ROW_W-1:0]    out_row_ff;
   logic [COL_W-1:0]    out_col_ff;
   logic                out_last_ff;

   // geometry in use, clamped to the legal range
   always_comb begin
      if (cfg.line_width < WIDTH_W'(MIN_SIZE)) begin
         eff_w = WIDTH_W'(MIN_SIZE);
      end else if (cfg.line_width > WIDTH_W'(MEM_DEPTH)) begin
         eff_w = WIDTH_W'(MEM_DEPTH);
      end else begin
         eff_w = cfg.line_width;
      end
      if (cfg.frame_height < HEIGHT_W'(MIN_SIZE)) begin
         eff_h = HEIGHT_W'(MIN_SIZE);
      end else if (cfg.frame_height > HEIGHT_W'(MAX_HEIGHT)) begin
         eff_h = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         eff_h = cfg.frame_height;
      end
   end

   // position: interior test, last pixel and counter step
   always_comb begin
      col_nxt  = {1'b0, col_ff} + 1'b1;
      row_nxt  = {1'b0, row_ff} + 1'b1;
      interior = ({1'b0, col_ff} < eff_w) && ({1'b0, row_ff} < eff_h)
                 && (col_ff >= COL_W'(2)) && (row_ff >= ROW_W'(2));
      last_pos = ({1'b0, row_ff} == eff_h - 1'b1)
                 && ({1'b0, col_ff} == eff_w - 1'b1);
      col_in = col_ff;
      row_in = row_ff;
      if (col_nxt >= eff_w) begin
         col_in = '0;
         row_in = (row_nxt >= eff_h) ? '0 : row_nxt[ROW_W-1:0];
      end else begin
         col_in = col_nxt[COL_W-1:0];
         if ({1'b0, row_ff} >= eff_h) begin
            row_in = '0;
         end
      end
   end

   // gradients; right column comes from the line stores and the new pixel
   always_comb begin
      kmr   = (cfg.kernel_mode == KERNEL_PREWITT) ? {1'b0, mid_rd_ff} : {mid_rd_ff, 1'b0};
      kml   = (cfg.kernel_mode == KERNEL_PREWITT) ? {1'b0, win_ff[1]} : {win_ff[1], 1'b0};
      kbm   = (cfg.kernel_mode == KERNEL_PREWITT) ? {1'b0, win_ff[5]} : {win_ff[5], 1'b0};
      ktm   = (cfg.kernel_mode == KERNEL_PREWITT) ? {1'b0, win_ff[3]} : {win_ff[3], 1'b0};
      pos_x = ABS_W'(top_rd_ff) + ABS_W'(kmr) + ABS_W'(pix_ff);
      neg_x = ABS_W'(win_ff[0]) + ABS_W'(kml) + ABS_W'(win_ff[2]);
      pos_y = ABS_W'(win_ff[2]) + ABS_W'(kbm) + ABS_W'(pix_ff);
      neg_y = ABS_W'(win_ff[0]) + ABS_W'(ktm) + ABS_W'(top_rd_ff);
      gx_in = $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
      gy_in = $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
   end

   // squares of the gradient magnitudes
   always_comb begin
      ax     = gx_ff[GRAD_W-1] ? ABS_W'(-gx_ff) : ABS_W'(gx_ff);
      ay     = gy_ff[GRAD_W-1] ? ABS_W'(-gy_ff) : ABS_W'(gy_ff);
      sqx    = ax * ax;
      sqy    = ay * ay;
      sq_sum = {1'b0, sqx} + {1'b0, sqy};
   end

   // line store ports: read on capture, write back on advance
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         top_rd_ff <= upper_mem[col_ff[ADDR_W-1:0]];
         mid_rd_ff <= middle_mem[col_ff[ADDR_W-1:0]];
      end
      if (cmd.advance) begin
         upper_mem[col_ff[ADDR_W-1:0]]  <= mid_rd_ff;
         middle_mem[col_ff[ADDR_W-1:0]] <= pix_ff;
      end
   end

   // window and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_SIZE; i++) begin
            win_ff[i] <= '0;
         end
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.advance) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= top_rd_ff;
         win_ff[4] <= mid_rd_ff;
         win_ff[5] <= pix_ff;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   // payload pipeline registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pix_ff <= pixel;
      end
      if (cmd.advance) begin
         gx_ff       <= gx_in;
         gy_ff       <= gy_in;
         res_row_ff  <= row_ff - 1'b1;
         res_col_ff  <= col_ff - 1'b1;
         res_last_ff <= last_pos;
      end
      if (cmd.square) begin
         sat_ff <= (sq_sum[SQ_W-1:ROOT_IN_W] != '0);
      end
   end

   gme_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.square),
      .value (sq_sum[ROOT_IN_W-1:0]),
      .busy  (root_busy),
      .root  (root)
   );

   // output register; holds its word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (out_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         out_mag_ff  <= sat_ff ? MAG_SAT : root;
         out_row_ff  <= res_row_ff;
         out_col_ff  <= res_col_ff;
         out_last_ff <= res_last_ff;
      end
   end

   assign sts.interior  = interior;
   assign sts.root_busy = root_busy;
   assign sts.out_free  = !out_valid_ff || out_ready;

   assign out_valid     = out_valid_ff;
   assign out_magnitude = out_mag_ff;
   assign out_row       = out_row_ff;
   assign out_column    = out_col_ff;
   assign out_last      = out_last_ff;
endmodule

// ----- hdl/gradient_magnitude_edge_3x3_top.sv -----
// Sobel / Prewitt 3x3 edge detector, top level.
// Depends on gme_pkg, gme_intf, gme_csr, gme_ctrl, gme_dpath.
//
// Usage:
//   req_ch  takes one 8-bit grey pixel word per handshake, raster order.
//   rsp_ch  gives one word per interior pixel: magnitude (floor root of
//           gx^2+gy^2, saturated to 255), row, column and last_of_frame.
//           Border pixels give no word.
//   csr_ch  writes line_width (index 0), frame_height (1), kernel_mode (2);
//           write only while the block is idle. ready is always high.
// Timing:
//   One pixel is worked on at a time; a border pixel only passes the read
//   state before the next accept. An interior pixel goes through gradient,
//   square, 8 root steps, a hand-off and the output register load, which
//   waits while that register is full. The next pixel can be accepted in
//   the cycle after the load.
// Reset: counters, window and output valid clear; registers take defaults.
//   The line stores are not cleared and need no clearing pass.
// Stall: a result waits in the output register while the next pixel is taken;
//   work holds only when a new result finds the register still full.
module gradient_magnitude_edge_3x3_top import gme_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   gme_req_if.sink  req_ch,
   gme_rsp_if.source rsp_ch,
   gme_csr_if.sink  csr_ch
);
   gme_cfg_type cfg;
   gme_cmd_type cmd;
   gme_sts_type sts;

   gme_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_ch.valid),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .csr_ready (csr_ch.ready),
      .cfg       (cfg)
   );

   gme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   gme_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .sts           (sts),
      .pixel         (req_ch.pixel),
      .out_valid     (rsp_ch.valid),
      .out_ready     (rsp_ch.ready),
      .out_magnitude (rsp_ch.magnitude),
      .out_row       (rsp_ch.row),
      .out_column    (rsp_ch.column),
      .out_last      (rsp_ch.last_of_frame)
   );
endmodule

// ----- hdl/gme_checker.sv -----
// Port-level checks for the edge detector top, attached by bind.
// Depends on gme_pkg and gradient_magnitude_edge_3x3_top.
module gme_checker import gme_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ROOT_W-1:0] rsp_magnitude,
   input logic [ROW_W-1:0]  rsp_row,
   input logic [COL_W-1:0]  rsp_column,
   input logic              rsp_last
);
   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_magnitude)
         && $stable(rsp_row) && $stable(rsp_column) && $stable(rsp_last))
      else $error("result word changed while stalled");

   // one pixel at a time: ready drops after each accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("pixel accepted while previous still in work");

   // results never for row 0 or column 0 (top and left border)
   a_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_row != '0 && rsp_column != '0)
      else $error("result for a border position");

   // a new result never follows an accept directly
   a_no_fast_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("result appeared right after an accept");
endmodule

bind gradient_magnitude_edge_3x3_top gme_checker u_gme_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_magnitude (rsp_ch.magnitude),
   .rsp_row       (rsp_ch.row),
   .rsp_column    (rsp_ch.column),
   .rsp_last      (rsp_ch.last_of_frame)
);
